@@ rtl/scr_pkg.sv @@
// scr_pkg: shared types and constants for the sphere collision response core
`default_nettype none
package scr_pkg;

   localparam int LANES     = 3;
   localparam int NUM_W     = 86;
   localparam int DEN_W     = 51;
   localparam int MAG_W     = 19;
   localparam int MEF_W     = 34;
   localparam int PROD_W    = 51;
   localparam int FRONT_LAT = 7;
   localparam int DIV_LAT   = 21;
   localparam int CORE_LAT  = FRONT_LAT + DIV_LAT + 1;
   localparam logic [MAG_W-1:0] MAG_LIMIT = 19'h40000;
   localparam logic [8:0] BOUNCE_ONE = 9'd256;
   localparam logic [17:0] EF_ONE = 18'h10000;

   typedef struct packed {
      logic [47:0] vel_a;
      logic [47:0] vel_b;
      logic [47:0] pos_a;
      logic [47:0] pos_b;
      logic [15:0] mass_a;
      logic [15:0] mass_b;
      logic [8:0]  bounce_a;
      logic [8:0]  bounce_b;
   } req_type;

   typedef struct packed {
      logic [47:0] new_vel_a;
      logic [47:0] new_vel_b;
      logic        centres_coincide;
      logic        saturated;
   } rsp_type;

   // per-word bookkeeping carried alongside the arithmetic
   typedef struct packed {
      logic [47:0]      vel_a;
      logic [47:0]      vel_b;
      logic [LANES-1:0] d_neg;
      logic             dot_neg;
      logic             coincide;
      logic             no_mass;
   } side_type;

endpackage
`default_nettype wire

@@ rtl/scr_front.sv @@
// scr_front: differences, dot products, denominator and numerators (7 stages)
`default_nettype none
module scr_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   input  wire scr_pkg::req_type      in_data,
   output logic                       out_valid,
   output scr_pkg::side_type          out_side,
   output logic [scr_pkg::DEN_W-1:0]  out_den,
   output logic [scr_pkg::NUM_W-1:0]  out_num [2][scr_pkg::LANES]
);
   localparam int L = scr_pkg::LANES;

   logic [6:0] valid_ff;
   scr_pkg::side_type side_ff [7];
   scr_pkg::side_type side_in;
   scr_pkg::side_type side3_in;

   // stage 1
   logic signed [16:0] d1_in [L], d1_ff [L], dv1_in [L], dv1_ff [L];
   logic [8:0] ea1_in, eb1_in, ea1_ff, eb1_ff;
   logic [15:0] ma1_ff, mb1_ff;
   logic [16:0] msum1_in, msum1_ff;
   // stage 2
   logic signed [33:0] dvd2_in [L], dvd2_ff [L];
   logic [31:0] dsq2_in [L], dsq2_ff [L];
   logic [15:0] dmag2_in [L], dmag2_ff [L];
   logic [17:0] ef2_in, ef2_ff;
   logic [15:0] ma2_ff, mb2_ff;
   logic [16:0] msum2_ff;
   // stage 3
   logic signed [35:0] dot3_in, dot3_ff;
   logic [33:0] dd3_in, dd3_ff;
   logic [33:0] maef3_in, mbef3_in, maef3_ff, mbef3_ff;
   logic [16:0] msum3_ff;
   logic [15:0] dmag3_ff [L];
   // stage 4
   logic signed [35:0] dabs4;
   logic [33:0] dmag4_in, dmag4_ff;
   logic [50:0] den4_in, den4_ff;
   logic [33:0] maef4_ff, mbef4_ff;
   logic [15:0] dmag4l_ff [L];
   // stage 5
   logic [49:0] prod5_in [L], prod5_ff [L];
   logic [50:0] den5_ff;
   logic [33:0] maef5_ff, mbef5_ff;
   // stage 6
   logic [scr_pkg::PROD_W-1:0] pp6_in [2][L][3], pp6_ff [2][L][3];
   logic [50:0] den6_ff;
   // stage 7
   logic [scr_pkg::NUM_W-1:0] num7_in [2][L], num7_ff [2][L];
   logic [50:0] den7_ff;

   always_comb begin
      logic signed [16:0] pa, pb, va, vb;
      for (int i = 0; i < L; i++) begin
         pa = 17'(signed'(in_data.pos_a[16*i +: 16]));
         pb = 17'(signed'(in_data.pos_b[16*i +: 16]));
         va = 17'(signed'(in_data.vel_a[16*i +: 16]));
         vb = 17'(signed'(in_data.vel_b[16*i +: 16]));
         d1_in[i] = pb - pa;
         dv1_in[i] = va - vb;
      end
      ea1_in = (in_data.bounce_a > scr_pkg::BOUNCE_ONE) ? scr_pkg::BOUNCE_ONE : in_data.bounce_a;
      eb1_in = (in_data.bounce_b > scr_pkg::BOUNCE_ONE) ? scr_pkg::BOUNCE_ONE : in_data.bounce_b;
      msum1_in = {1'b0, in_data.mass_a} + {1'b0, in_data.mass_b};
      side_in.vel_a = in_data.vel_a;
      side_in.vel_b = in_data.vel_b;
      for (int i = 0; i < L; i++) side_in.d_neg[i] = d1_in[i][16];
      side_in.dot_neg = 1'b0;
      side_in.coincide = (in_data.pos_a == in_data.pos_b);
      side_in.no_mass = (msum1_in == 17'd0);
   end

   always_comb begin
      for (int i = 0; i < L; i++) begin
         dvd2_in[i] = 34'(dv1_ff[i]) * 34'(d1_ff[i]);
         dmag2_in[i] = d1_ff[i][16] ? 16'(-d1_ff[i]) : d1_ff[i][15:0];
         dsq2_in[i] = dmag2_in[i] * dmag2_in[i];
      end
      ef2_in = scr_pkg::EF_ONE + 18'(ea1_ff * eb1_ff);
   end

   always_comb begin
      dot3_in = 36'(dvd2_ff[0]) + 36'(dvd2_ff[1]) + 36'(dvd2_ff[2]);
      dd3_in = 34'(dsq2_ff[0]) + 34'(dsq2_ff[1]) + 34'(dsq2_ff[2]);
      maef3_in = 34'(ma2_ff) * 34'(ef2_ff);
      mbef3_in = 34'(mb2_ff) * 34'(ef2_ff);
   end

   always_comb begin
      side3_in = side_ff[2];
      side3_in.dot_neg = dot3_ff[35];
   end

   always_comb begin
      dabs4 = dot3_ff[35] ? -dot3_ff : dot3_ff;
      dmag4_in = dabs4[33:0];
      den4_in = 51'(msum3_ff) * 51'(dd3_ff);
   end

   always_comb begin
      for (int i = 0; i < L; i++) prod5_in[i] = 50'(dmag4_ff) * 50'(dmag4l_ff[i]);
   end

   always_comb begin
      logic [50:0] p;
      for (int i = 0; i < L; i++) begin
         p = 51'(prod5_ff[i]);
         for (int j = 0; j < 3; j++) begin
            pp6_in[0][i][j] = 51'(mbef5_ff) * 51'(p[17*j +: 17]);
            pp6_in[1][i][j] = 51'(maef5_ff) * 51'(p[17*j +: 17]);
         end
      end
   end

   // numerator plus half the divisor for round to nearest
   always_comb begin
      for (int k = 0; k < 2; k++)
         for (int i = 0; i < L; i++)
            num7_in[k][i] = 86'(pp6_ff[k][i][0]) + (86'(pp6_ff[k][i][1]) << 17)
                          + (86'(pp6_ff[k][i][2]) << 34) + (86'(den6_ff) << 15);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[5:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= side_in;
      side_ff[1] <= side_ff[0];
      side_ff[2] <= side_ff[1];
      side_ff[3] <= side3_in;
      side_ff[4] <= side_ff[3];
      side_ff[5] <= side_ff[4];
      side_ff[6] <= side_ff[5];
      d1_ff <= d1_in;
      dv1_ff <= dv1_in;
      ea1_ff <= ea1_in;
      eb1_ff <= eb1_in;
      ma1_ff <= in_data.mass_a;
      mb1_ff <= in_data.mass_b;
      msum1_ff <= msum1_in;
      dvd2_ff <= dvd2_in;
      dsq2_ff <= dsq2_in;
      dmag2_ff <= dmag2_in;
      ef2_ff <= ef2_in;
      ma2_ff <= ma1_ff;
      mb2_ff <= mb1_ff;
      msum2_ff <= msum1_ff;
      dot3_ff <= dot3_in;
      dd3_ff <= dd3_in;
      maef3_ff <= maef3_in;
      mbef3_ff <= mbef3_in;
      msum3_ff <= msum2_ff;
      dmag3_ff <= dmag2_ff;
      dmag4_ff <= dmag4_in;
      den4_ff <= den4_in;
      maef4_ff <= maef3_ff;
      mbef4_ff <= mbef3_ff;
      dmag4l_ff <= dmag3_ff;
      prod5_ff <= prod5_in;
      den5_ff <= den4_ff;
      maef5_ff <= maef4_ff;
      mbef5_ff <= mbef4_ff;
      pp6_ff <= pp6_in;
      den6_ff <= den5_ff;
      num7_ff <= num7_in;
      den7_ff <= den6_ff;
   end

   assign out_valid = valid_ff[6];
   assign out_side = side_ff[6];
   assign out_den = den7_ff;
   assign out_num = num7_ff;

endmodule
`default_nettype wire

@@ rtl/scr_div.sv @@
// scr_div: pipelined restoring divider, one quotient bit per stage, limited magnitude
`default_nettype none
module scr_div (
   input  wire logic                       clock,
   input  wire logic [scr_pkg::NUM_W-1:0]  num,
   input  wire logic [scr_pkg::DEN_W-1:0]  den,
   output logic [scr_pkg::MAG_W-1:0]       mag
);
   localparam int QB = scr_pkg::MAG_W;
   localparam int NW = scr_pkg::NUM_W;

   logic [NW-1:0] rem_ff [QB+1];
   logic [NW-1:0] rem_in [QB+1];
   logic [scr_pkg::DEN_W-1:0] den_ff [QB+1];
   logic [QB-1:0] q_ff [QB+1];
   logic [QB-1:0] q_in [QB+1];
   logic ovf_ff [QB+1];
   logic [QB-1:0] mag_ff, mag_in;

   always_ff @(posedge clock) begin
      rem_ff[0] <= num;
      den_ff[0] <= den;
      q_ff[0] <= '0;
      ovf_ff[0] <= (num >= (NW'(den) << (16 + QB)));
   end

   for (genvar k = 0; k < QB; k++) begin : g_stage
      localparam int B = QB - 1 - k;
      always_comb begin
         logic [NW-1:0] sub;
         sub = NW'(den_ff[k]) << (16 + B);
         rem_in[k+1] = rem_ff[k];
         q_in[k+1] = q_ff[k];
         if (rem_ff[k] >= sub) begin
            rem_in[k+1] = rem_ff[k] - sub;
            q_in[k+1][B] = 1'b1;
         end
      end
      always_ff @(posedge clock) begin
         rem_ff[k+1] <= rem_in[k+1];
         q_ff[k+1] <= q_in[k+1];
         den_ff[k+1] <= den_ff[k];
         ovf_ff[k+1] <= ovf_ff[k];
      end
   end

   assign rem_in[0] = '0;
   assign q_in[0] = '0;

   always_comb begin
      if (ovf_ff[QB] || (q_ff[QB] > scr_pkg::MAG_LIMIT)) mag_in = scr_pkg::MAG_LIMIT;
      else mag_in = q_ff[QB];
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
   end

   assign mag = mag_ff;

endmodule
`default_nettype wire

@@ rtl/sphere_collision_response_core.sv @@
// sphere_collision_response_core: two-sphere collision response with restitution, top level
//
//   channel | ports                      | direction | accepted when
//   request | start, busy, req_data      | in        | start high, busy low
//   result  | rsp_strobe, rsp_data       | out       | every strobe cycle
//
// A word enters every cycle; busy is always low.
// The pipeline has 7 front stages, 21 divider stages (one quotient bit
// each, plus entry and limit) and 1 output register.
// Reset clears all valid bits; words in flight are dropped.
// The receiver cannot stall, so nothing ever holds back the pipeline.
`default_nettype none
module sphere_collision_response_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire scr_pkg::req_type  req_data,
   output logic                   rsp_strobe,
   output scr_pkg::rsp_type       rsp_data
);
   localparam int L = scr_pkg::LANES;
   localparam int DL = scr_pkg::DIV_LAT;

   logic f_valid;
   scr_pkg::side_type f_side;
   logic [scr_pkg::DEN_W-1:0] f_den;
   logic [scr_pkg::NUM_W-1:0] f_num [2][L];
   logic [scr_pkg::MAG_W-1:0] mag [2][L];

   logic [DL-1:0] dvalid_ff;
   scr_pkg::side_type dside_ff [DL];
   logic rsp_valid_ff;
   scr_pkg::rsp_type rsp_ff, rsp_in;

   assign busy = 1'b0;

   scr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start & ~busy),
      .in_data   (req_data),
      .out_valid (f_valid),
      .out_side  (f_side),
      .out_den   (f_den),
      .out_num   (f_num)
   );

   for (genvar k = 0; k < 2; k++) begin : g_side
      for (genvar i = 0; i < L; i++) begin : g_lane
         scr_div u_div (
            .clock (clock),
            .num   (f_num[k][i]),
            .den   (f_den),
            .mag   (mag[k][i])
         );
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dvalid_ff <= '0;
      end else begin
         dvalid_ff <= {dvalid_ff[DL-2:0], f_valid};
      end
   end

   always_ff @(posedge clock) begin
      dside_ff[0] <= f_side;
      for (int s = 1; s < DL; s++) dside_ff[s] <= dside_ff[s-1];
   end

   always_comb begin
      scr_pkg::side_type sd;
      logic signed [20:0] delta, ra, rb;
      logic sat;
      sd = dside_ff[DL-1];
      sat = 1'b0;
      rsp_in.new_vel_a = '0;
      rsp_in.new_vel_b = '0;
      for (int i = 0; i < L; i++) begin
         delta = 21'(mag[0][i]);
         if (sd.dot_neg ^ sd.d_neg[i]) delta = -delta;
         ra = 21'(signed'(sd.vel_a[16*i +: 16])) - delta;
         delta = 21'(mag[1][i]);
         if (sd.dot_neg ^ sd.d_neg[i]) delta = -delta;
         rb = 21'(signed'(sd.vel_b[16*i +: 16])) + delta;
         if (ra > 21'sd32767) begin
            rsp_in.new_vel_a[16*i +: 16] = 16'h7fff;
            sat = 1'b1;
         end else if (ra < -21'sd32768) begin
            rsp_in.new_vel_a[16*i +: 16] = 16'h8000;
            sat = 1'b1;
         end else begin
            rsp_in.new_vel_a[16*i +: 16] = ra[15:0];
         end
         if (rb > 21'sd32767) begin
            rsp_in.new_vel_b[16*i +: 16] = 16'h7fff;
            sat = 1'b1;
         end else if (rb < -21'sd32768) begin
            rsp_in.new_vel_b[16*i +: 16] = 16'h8000;
            sat = 1'b1;
         end else begin
            rsp_in.new_vel_b[16*i +: 16] = rb[15:0];
         end
      end
      rsp_in.saturated = sat;
      rsp_in.centres_coincide = sd.coincide;
      if (sd.coincide || sd.no_mass) begin
         rsp_in.new_vel_a = sd.vel_a;
         rsp_in.new_vel_b = sd.vel_b;
         rsp_in.saturated = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dvalid_ff[DL-1];
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, scr_pkg::CORE_LAT))
      else $error("result word without a request");

   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_data.centres_coincide && rsp_data.saturated))
      else $error("coincident centres flagged as saturated");

   a_pass: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.centres_coincide |->
         rsp_data.new_vel_a == $past(req_data.vel_a, scr_pkg::CORE_LAT))
      else $error("coincident centres did not pass velocity through");

endmodule
`default_nettype wire
